/* design/png_sv_pkg.sv */
// Package for the PNG stream validator: verdict codes, PNG constants and
// the byte-wise CRC-32 and signature byte helpers. No dependencies.
package png_sv_pkg;

    // verdict codes
    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_BAD_SIG   = 3'd1,
        VERDICT_ORDER     = 3'd2,
        VERDICT_CRITICAL  = 3'd3,
        VERDICT_CRC       = 3'd4,
        VERDICT_TRUNCATED = 3'd5
    } verdict_t;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [63:0] PNG_SIG    = 64'h8950_4E47_0D0A_1A0A;
    localparam logic [31:0] TYPE_IHDR  = 32'h4948_4452;
    localparam logic [31:0] TYPE_IDAT  = 32'h4944_4154;
    localparam logic [31:0] TYPE_IEND  = 32'h4945_4E44;
    localparam logic [31:0] TYPE_PLTE  = 32'h504C_5445;
    localparam logic [7:0]  LOWER_A    = 8'h61;
    localparam logic [7:0]  LOWER_Z    = 8'h7A;
    localparam int          MIN_IMAGE_LEN = 44;

    // reflected crc-32 update by one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data_in);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data_in};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    // expected signature byte at position idx, first byte at idx 0
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [63:0] shifted;
        shifted = PNG_SIG >> {~idx, 3'b000};
        return shifted[7:0];
    endfunction

endpackage

/* design/png_stream_validator_core.sv */
// Top level of the PNG stream validator: byte parser, chunk order and CRC
// checks, and a two-entry result buffer. Depends on png_sv_pkg.

// The block takes one byte per cycle on the item channel while item_ready
// is high; each byte is parsed combinationally, the longest path being
// the eight-step CRC-32 update of one byte. A byte with first_byte set
// restarts the parser. At most one result request is made per stream,
// registered from the byte that decides it: at a good IEND crc, at the
// first error, or at the byte marked last_byte. The output register plus
// one skid entry let the parser keep taking bytes while a result waits;
// item_ready drops only when both entries are full. image_length counts
// the bytes of the stream up to and including the deciding byte and
// saturates at all ones.
module png_stream_validator_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic [7:0]            data_byte,
    input  logic                  first_byte,
    input  logic                  last_byte,
    output logic                  result_valid,
    input  logic                  result_ready,
    output png_sv_pkg::verdict_t  verdict,
    output logic [31:0]           image_length
);
    import png_sv_pkg::*;

    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC  = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next, phase_eff;
    logic [31:0] field_count_reg, field_count_next, field_count_eff;
    logic [31:0] chunk_length_reg, chunk_length_next, chunk_length_eff;
    logic [31:0] chunk_type_reg, chunk_type_next, chunk_type_eff;
    logic [31:0] running_crc_reg, running_crc_next, running_crc_eff;
    logic [31:0] stored_crc_reg, stored_crc_next, stored_crc_eff;
    logic        seen_header_reg, seen_header_next, seen_header_eff;
    logic        seen_data_reg, seen_data_next, seen_data_eff;
    logic [31:0] total_count_reg, total_count_next, total_count_eff;
    logic        finished_reg, finished_next, finished_eff;

    logic        out_valid_reg;
    verdict_t    out_verdict_reg;
    logic [31:0] out_length_reg;
    logic        skid_valid_reg;
    verdict_t    skid_verdict_reg;
    logic [31:0] skid_length_reg;

    logic        accept;
    logic        out_take;
    logic        have_result;
    verdict_t    result_code;
    logic [31:0] count_inc;

    assign item_ready   = !skid_valid_reg;
    assign accept       = item_valid && item_ready;
    assign result_valid = out_valid_reg;
    assign verdict      = out_verdict_reg;
    assign image_length = out_length_reg;
    assign out_take     = out_valid_reg && result_ready;
    assign count_inc    = field_count_eff + 32'd1;

    // parser state as seen by this byte, reset first when a stream starts
    always_comb
    begin
        if (first_byte)
        begin
            phase_eff        = PH_SIG;
            field_count_eff  = '0;
            chunk_length_eff = '0;
            chunk_type_eff   = '0;
            running_crc_eff  = ALL_ONES;
            stored_crc_eff   = '0;
            seen_header_eff  = 1'b0;
            seen_data_eff    = 1'b0;
            total_count_eff  = '0;
            finished_eff     = 1'b0;
        end
        else
        begin
            phase_eff        = phase_reg;
            field_count_eff  = field_count_reg;
            chunk_length_eff = chunk_length_reg;
            chunk_type_eff   = chunk_type_reg;
            running_crc_eff  = running_crc_reg;
            stored_crc_eff   = stored_crc_reg;
            seen_header_eff  = seen_header_reg;
            seen_data_eff    = seen_data_reg;
            total_count_eff  = total_count_reg;
            finished_eff     = finished_reg;
        end
    end

    // one byte of parsing
    always_comb
    begin
        phase_next        = phase_eff;
        field_count_next  = field_count_eff;
        chunk_length_next = chunk_length_eff;
        chunk_type_next   = chunk_type_eff;
        running_crc_next  = running_crc_eff;
        stored_crc_next   = stored_crc_eff;
        seen_header_next  = seen_header_eff;
        seen_data_next    = seen_data_eff;
        total_count_next  = total_count_eff;
        finished_next     = finished_eff;
        have_result       = 1'b0;
        result_code       = VERDICT_OK;

        if (!finished_eff)
        begin
            if (total_count_eff != ALL_ONES)
            begin
                total_count_next = total_count_eff + 32'd1;
            end

            case (phase_eff)
                PH_SIG:
                begin
                    if (data_byte != sig_byte(field_count_eff[2:0]))
                    begin
                        have_result = 1'b1;
                        result_code = VERDICT_BAD_SIG;
                    end
                    else if (count_inc == 32'd8)
                    begin
                        phase_next       = PH_LEN;
                        field_count_next = '0;
                    end
                    else
                    begin
                        field_count_next = count_inc;
                    end
                end
                PH_LEN:
                begin
                    chunk_length_next = {chunk_length_eff[23:0], data_byte};
                    if (count_inc == 32'd4)
                    begin
                        phase_next       = PH_TYPE;
                        field_count_next = '0;
                        running_crc_next = ALL_ONES;
                    end
                    else
                    begin
                        field_count_next = count_inc;
                    end
                end
                PH_TYPE:
                begin
                    chunk_type_next  = {chunk_type_eff[23:0], data_byte};
                    running_crc_next = crc_byte(running_crc_eff, data_byte);
                    if (count_inc == 32'd4)
                    begin
                        field_count_next = '0;
                        phase_next = (chunk_length_eff != 32'd0) ? PH_DATA : PH_CRC;
                        // chunk order and critical chunk rules
                        case (chunk_type_next)
                            TYPE_IHDR:
                            begin
                                if (seen_header_eff)
                                begin
                                    have_result = 1'b1;
                                    result_code = VERDICT_ORDER;
                                end
                                else
                                begin
                                    seen_header_next = 1'b1;
                                end
                            end
                            TYPE_IDAT:
                            begin
                                if (!seen_header_eff)
                                begin
                                    have_result = 1'b1;
                                    result_code = VERDICT_ORDER;
                                end
                                else
                                begin
                                    seen_data_next = 1'b1;
                                end
                            end
                            TYPE_IEND:
                            begin
                                if (!seen_header_eff || !seen_data_eff)
                                begin
                                    have_result = 1'b1;
                                    result_code = VERDICT_ORDER;
                                end
                            end
                            TYPE_PLTE:
                            begin
                                if (!seen_header_eff)
                                begin
                                    have_result = 1'b1;
                                    result_code = VERDICT_ORDER;
                                end
                            end
                            default:
                            begin
                                if (!seen_header_eff)
                                begin
                                    have_result = 1'b1;
                                    result_code = VERDICT_ORDER;
                                end
                                else if (!(chunk_type_next[31:24] inside
                                           {[LOWER_A:LOWER_Z]}))
                                begin
                                    have_result = 1'b1;
                                    result_code = VERDICT_CRITICAL;
                                end
                            end
                        endcase
                    end
                    else
                    begin
                        field_count_next = count_inc;
                    end
                end
                PH_DATA:
                begin
                    running_crc_next = crc_byte(running_crc_eff, data_byte);
                    if (count_inc == chunk_length_eff)
                    begin
                        phase_next       = PH_CRC;
                        field_count_next = '0;
                    end
                    else
                    begin
                        field_count_next = count_inc;
                    end
                end
                default:
                begin
                    stored_crc_next = {stored_crc_eff[23:0], data_byte};
                    if (count_inc == 32'd4)
                    begin
                        field_count_next = '0;
                        if (stored_crc_next != (running_crc_eff ^ ALL_ONES))
                        begin
                            have_result = 1'b1;
                            result_code = VERDICT_CRC;
                        end
                        else if (chunk_type_eff == TYPE_IEND)
                        begin
                            have_result = 1'b1;
                            result_code = VERDICT_OK;
                        end
                        else
                        begin
                            phase_next = PH_LEN;
                        end
                    end
                    else
                    begin
                        field_count_next = count_inc;
                    end
                end
            endcase

            // end of buffer without a verdict
            if (!have_result && last_byte)
            begin
                have_result = 1'b1;
                result_code = VERDICT_TRUNCATED;
            end
            if (have_result)
            begin
                finished_next = 1'b1;
            end
        end
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SIG;
            field_count_reg  <= '0;
            chunk_length_reg <= '0;
            chunk_type_reg   <= '0;
            running_crc_reg  <= ALL_ONES;
            stored_crc_reg   <= '0;
            seen_header_reg  <= 1'b0;
            seen_data_reg    <= 1'b0;
            total_count_reg  <= '0;
            finished_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            field_count_reg  <= field_count_next;
            chunk_length_reg <= chunk_length_next;
            chunk_type_reg   <= chunk_type_next;
            running_crc_reg  <= running_crc_next;
            stored_crc_reg   <= stored_crc_next;
            seen_header_reg  <= seen_header_next;
            seen_data_reg    <= seen_data_next;
            total_count_reg  <= total_count_next;
            finished_reg     <= finished_next;
        end
    end

    // result buffer control: output register and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept && have_result)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_verdict_reg <= skid_verdict_reg;
                out_length_reg  <= skid_length_reg;
            end
        end
        else if (accept && have_result)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_verdict_reg <= result_code;
                skid_length_reg  <= total_count_next;
            end
            else
            begin
                out_verdict_reg <= result_code;
                out_length_reg  <= total_count_next;
            end
        end
    end

    // skid entry is only used behind a waiting output
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output register empty");

    // a decided byte closes the stream
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && have_result) |=> finished_reg)
        else $error("stream not closed after its verdict");

    // a valid image holds at least signature, IHDR, IDAT and IEND
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_verdict_reg == VERDICT_OK)
            |-> (out_length_reg >= 32'(MIN_IMAGE_LEN)))
        else $error("valid verdict with too short an image");

    // no chunk has been seen while the signature is still being checked
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SIG) |-> (!seen_header_reg && !seen_data_reg))
        else $error("chunk flags set during signature phase");

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Testbench for png_stream_validator_core: drives generated PNG byte streams
// and checks each verdict and image length against a byte-level predictor.
// Depends on png_sv_pkg and the design files.
module testbench;
    import png_sv_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int CHOKE_CYCLES = 400;

    typedef enum logic [2:0] {
        SCAN_SIG,
        SCAN_LEN,
        SCAN_TYPE,
        SCAN_DATA,
        SCAN_CRC
    } scan_phase_t;

    // one byte request plus sequencing marks for the driver
    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       last;
        bit         choke;
        bit         drain;
    } byte_req_t;

    typedef struct {
        verdict_t    code;
        logic [31:0] length;
    } verdict_rec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        first_byte = 1'b0;
    logic        last_byte = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    verdict_t    verdict;
    logic [31:0] image_length;

    // outputs sampled mid-cycle
    logic        s_item_ready = 1'b0;
    logic        s_res_valid = 1'b0;
    verdict_t    s_verdict;
    logic [31:0] s_length;

    byte_req_t    byte_queue[$];
    verdict_rec_t pending_verdicts[$];
    logic [7:0]   sbuf[$];

    // predictor state
    scan_phase_t scan_phase;
    logic [31:0] scan_field;
    logic [31:0] chunk_len;
    logic [31:0] chunk_tag;
    logic [31:0] run_crc;
    logic [31:0] got_crc;
    bit          have_hdr;
    bit          have_idat;
    logic [31:0] scan_total;
    bit          scan_done;

    // driver and receiver bookkeeping
    byte_req_t offered;
    bit        start_choke;
    int        send_gap = 0;
    int        burst_left = 0;
    logic      choke_pulse = 1'b0;
    int        hold_left = 0;
    int        rx_run = 0;
    bit        rx_on = 1'b0;
    bit        ready_next;

    verdict_rec_t want;
    int errors = 0;
    int bytes_taken = 0;
    int streams_built = 0;
    int checked = 0;
    int tally[8];
    int cycles = 0;

    png_stream_validator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .data_byte    (data_byte),
        .first_byte   (first_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .verdict      (verdict),
        .image_length (image_length)
    );

    always #5 clk = ~clk;

    // reflected crc-32, data bits folded into the feedback term
    function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c;
        for (int i = 0; i < 8; i++)
        begin
            r = (r >> 1) ^ (CRC_POLY & {32{r[0] ^ b[i]}});
        end
        return r;
    endfunction

    task automatic clear_parser();
        scan_phase = SCAN_SIG;
        scan_field = 32'd0;
        chunk_len  = 32'd0;
        chunk_tag  = 32'd0;
        run_crc    = ALL_ONES;
        got_crc    = 32'd0;
        have_hdr   = 1'b0;
        have_idat  = 1'b0;
        scan_total = 32'd0;
        scan_done  = 1'b0;
    endtask

    // advance the predicted parser by one byte, queue a verdict if one falls
    task automatic judge_byte(input byte_req_t r);
        verdict_t     v;
        bit           decided;
        logic [63:0]  sig_shift;
        logic [7:0]   lead;
        verdict_rec_t rec;
        v = VERDICT_OK;
        decided = 1'b0;
        if (r.first)
            clear_parser();
        if (scan_done)
            return;
        if (scan_total != ALL_ONES)
            scan_total++;
        case (scan_phase)
            SCAN_SIG:
            begin
                sig_shift = PNG_SIG >> (8 * (7 - scan_field[2:0]));
                if (r.data != sig_shift[7:0])
                begin
                    v = VERDICT_BAD_SIG;
                    decided = 1'b1;
                end
                else
                begin
                    scan_field++;
                    if (scan_field == 32'd8)
                    begin
                        scan_phase = SCAN_LEN;
                        scan_field = 32'd0;
                    end
                end
            end
            SCAN_LEN:
            begin
                chunk_len = {chunk_len[23:0], r.data};
                scan_field++;
                if (scan_field == 32'd4)
                begin
                    scan_phase = SCAN_TYPE;
                    scan_field = 32'd0;
                    run_crc = ALL_ONES;
                end
            end
            SCAN_TYPE:
            begin
                chunk_tag = {chunk_tag[23:0], r.data};
                run_crc = crc32_step(run_crc, r.data);
                scan_field++;
                if (scan_field == 32'd4)
                begin
                    scan_field = 32'd0;
                    scan_phase = (chunk_len != 32'd0) ? SCAN_DATA : SCAN_CRC;
                    lead = chunk_tag[31:24];
                    // chunk order rules, judged on the last type byte
                    if (chunk_tag == TYPE_IHDR)
                    begin
                        if (have_hdr)
                            v = VERDICT_ORDER;
                        have_hdr = 1'b1;
                    end
                    else if (chunk_tag == TYPE_IDAT)
                    begin
                        if (!have_hdr)
                            v = VERDICT_ORDER;
                        else
                            have_idat = 1'b1;
                    end
                    else if (chunk_tag == TYPE_IEND)
                    begin
                        if (!have_hdr || !have_idat)
                            v = VERDICT_ORDER;
                    end
                    else if (chunk_tag == TYPE_PLTE)
                    begin
                        if (!have_hdr)
                            v = VERDICT_ORDER;
                    end
                    else if (!have_hdr)
                        v = VERDICT_ORDER;
                    else if (lead < LOWER_A || lead > LOWER_Z)
                        v = VERDICT_CRITICAL;
                    decided = (v != VERDICT_OK);
                end
            end
            SCAN_DATA:
            begin
                run_crc = crc32_step(run_crc, r.data);
                scan_field++;
                if (scan_field == chunk_len)
                begin
                    scan_phase = SCAN_CRC;
                    scan_field = 32'd0;
                end
            end
            default:
            begin
                got_crc = {got_crc[23:0], r.data};
                scan_field++;
                if (scan_field == 32'd4)
                begin
                    scan_field = 32'd0;
                    if (got_crc != ~run_crc)
                    begin
                        v = VERDICT_CRC;
                        decided = 1'b1;
                    end
                    else if (chunk_tag == TYPE_IEND)
                        decided = 1'b1;
                    else
                        scan_phase = SCAN_LEN;
                end
            end
        endcase
        if (!decided && r.last)
        begin
            v = VERDICT_TRUNCATED;
            decided = 1'b1;
        end
        if (decided)
        begin
            scan_done = 1'b1;
            rec.code = v;
            rec.length = scan_total;
            pending_verdicts.push_back(rec);
        end
    endtask

    // stream building
    task automatic push_req(input logic [7:0] d, input logic f, input logic l,
                            input bit ch = 1'b0, input bit dr = 1'b0);
        byte_req_t r;
        r.data = d;
        r.first = f;
        r.last = l;
        r.choke = ch;
        r.drain = dr;
        byte_queue.push_back(r);
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
        begin
            sbuf.push_back(w[8*i +: 8]);
        end
    endtask

    task automatic put_sig();
        for (int i = 7; i >= 0; i--)
        begin
            sbuf.push_back(PNG_SIG[8*i +: 8]);
        end
    endtask

    // length, type, random data and crc; spoil flips one crc bit
    task automatic put_chunk(input logic [31:0] tag, input int unsigned dlen, input bit spoil);
        logic [31:0] c;
        logic [7:0]  d;
        c = ALL_ONES;
        put_word(dlen);
        put_word(tag);
        for (int k = 3; k >= 0; k--)
        begin
            c = crc32_step(c, tag[8*k +: 8]);
        end
        for (int i = 0; i < dlen; i++)
        begin
            d = 8'($urandom);
            sbuf.push_back(d);
            c = crc32_step(c, d);
        end
        c = ~c;
        if (spoil)
            c ^= 32'h1 << $urandom_range(0, 31);
        put_word(c);
    endtask

    function automatic int unsigned rand_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 6);
    endfunction

    // ancillary tag when lower is set, else a tag with a non-lowercase lead
    function automatic logic [31:0] odd_tag(input bit lower);
        logic [7:0]  lead;
        logic [23:0] tail;
        if (lower)
            lead = 8'($urandom_range(LOWER_A, LOWER_Z));
        else if ($urandom_range(0, 1) != 0)
            lead = 8'($urandom_range(0, 8'h60));
        else
            lead = 8'($urandom_range(8'h7B, 8'hFF));
        tail = 24'($urandom);
        return {lead, tail};
    endfunction

    task automatic emit_stream(input bit with_last, input bit with_first = 1'b1,
                               input bit with_drain = 1'b0);
        for (int i = 0; i < sbuf.size(); i++)
        begin
            push_req(sbuf[i], with_first && i == 0, with_last && i == sbuf.size() - 1,
                     1'b0, with_drain && i == 0);
        end
        sbuf.delete();
        streams_built++;
    endtask

    task automatic build_random_stream(input bit with_drain);
        int unsigned kind;
        int unsigned n;
        int unsigned pos;
        int unsigned bad;
        logic [7:0]  d;
        kind = $urandom_range(0, 99);
        put_sig();
        if (kind < 60)
        begin
            // mostly well formed, with occasional damage
            put_chunk(TYPE_IHDR, rand_len(), 1'b0);
            repeat ($urandom_range(0, 2)) put_chunk(odd_tag(1'b1), rand_len(), 1'b0);
            if ($urandom_range(0, 1) != 0)
                put_chunk(TYPE_PLTE, rand_len(), 1'b0);
            repeat ($urandom_range(1, 3)) put_chunk(TYPE_IDAT, rand_len(), 1'b0);
            if ($urandom_range(0, 2) == 0)
                put_chunk(odd_tag(1'b1), rand_len(), 1'b0);
            put_chunk(TYPE_IEND, ($urandom_range(0, 3) == 0) ? rand_len() : 0, 1'b0);
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    pos = $urandom_range(0, sbuf.size() - 1);
                    d = 8'($urandom);
                    sbuf[pos] = d;
                end
                2, 3:
                begin
                    n = $urandom_range(1, sbuf.size() - 1);
                    while (sbuf.size() > n)
                        void'(sbuf.pop_back());
                end
                4:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        d = 8'($urandom);
                        sbuf.push_back(d);
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (kind < 80)
        begin
            // chunk order and critical chunk errors
            case ($urandom_range(0, 5))
                0: put_chunk(TYPE_IDAT, rand_len(), 1'b0);
                1: put_chunk(TYPE_IHDR, rand_len(), 1'b0);
                2:
                begin
                    put_chunk(TYPE_IHDR, rand_len(), 1'b0);
                    put_chunk(TYPE_IHDR, rand_len(), 1'b0);
                end
                3:
                begin
                    put_chunk(TYPE_IHDR, rand_len(), 1'b0);
                    put_chunk(TYPE_IDAT, rand_len(), 1'b0);
                    put_chunk(odd_tag(1'b0), rand_len(), 1'b0);
                end
                4: put_chunk(odd_tag(1'($urandom_range(0, 1))), rand_len(), 1'b0);
                default: put_chunk(TYPE_PLTE, rand_len(), 1'b0);
            endcase
            put_chunk(TYPE_IEND, 0, 1'b0);
        end
        else if (kind < 90)
        begin
            // one chunk carries a wrong crc
            bad = $urandom_range(0, 2);
            put_chunk(TYPE_IHDR, rand_len(), bad == 0);
            put_chunk(TYPE_IDAT, rand_len(), bad == 1);
            put_chunk(TYPE_IEND, 0, bad == 2);
        end
        else
        begin
            // noise after part or all of the signature
            n = $urandom_range(0, 8);
            while (sbuf.size() > n)
                void'(sbuf.pop_back());
            repeat ($urandom_range(1, 12))
            begin
                d = 8'($urandom);
                sbuf.push_back(d);
            end
        end
        emit_stream($urandom_range(0, 9) != 0, $urandom_range(0, 19) != 0, with_drain);
    endtask

    // sample dut outputs away from the active edge
    always @(negedge clk)
    begin
        s_item_ready <= item_ready;
        s_res_valid  <= result_valid;
        s_verdict    <= verdict;
        s_length     <= image_length;
    end

    // byte driver: bursts with random gaps, drain and choke marks
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid  <= 1'b0;
            data_byte   <= 8'd0;
            first_byte  <= 1'b0;
            last_byte   <= 1'b0;
            choke_pulse <= 1'b0;
        end
        else
        begin
            // request taken at this edge
            if (item_valid && s_item_ready)
            begin
                judge_byte(offered);
                bytes_taken++;
            end
            start_choke = 1'b0;
            if (!item_valid || s_item_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (byte_queue.size() == 0)
                    item_valid <= 1'b0;
                else if (byte_queue[0].drain && pending_verdicts.size() != 0)
                    item_valid <= 1'b0;
                else
                begin
                    offered = byte_queue.pop_front();
                    start_choke = offered.choke;
                    item_valid <= 1'b1;
                    data_byte  <= offered.data;
                    first_byte <= offered.first;
                    last_byte  <= offered.last;
                    if (burst_left != 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(0, 20);
                        send_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                               : $urandom_range(1, 4);
                    end
                end
            end
            choke_pulse <= start_choke;
        end
    end

    // result receiver: alternating ready and stall runs, long hold on choke
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (choke_pulse)
                hold_left = CHOKE_CYCLES;
            if (hold_left != 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
            begin
                if (rx_run == 0)
                begin
                    rx_on = !rx_on;
                    if (rx_on)
                        rx_run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                             : $urandom_range(1, 30);
                    else
                        rx_run = $urandom_range(1, 8);
                end
                rx_run--;
                ready_next = rx_on;
            end
            result_ready <= ready_next;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && s_res_valid && result_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t unexpected result: verdict %0d, length %0d",
                         $time, s_verdict, s_length);
                errors++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                checked++;
                tally[want.code]++;
                if (want.code !== s_verdict)
                begin
                    $display("%0t verdict mismatch: expected %0d, actual %0d",
                             $time, want.code, s_verdict);
                    errors++;
                end
                if (want.length !== s_length)
                begin
                    $display("%0t image_length mismatch: expected %0d, actual %0d",
                             $time, want.length, s_length);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d verdicts outstanding",
                     cycles, pending_verdicts.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        foreach (tally[i])
            tally[i] = 0;
        clear_parser();

        // parser starts from reset without a first mark; last after verdict ignored
        push_req(8'h00, 1'b0, 1'b0);
        push_req(8'h89, 1'b0, 1'b1);
        push_req(8'hFF, 1'b1, 1'b1);
        // truncated inside the signature
        push_req(8'h89, 1'b1, 1'b0);
        push_req(8'h50, 1'b0, 1'b1);
        // smallest valid image, all chunks empty
        put_sig();
        put_chunk(TYPE_IHDR, 0, 1'b0);
        put_chunk(TYPE_IDAT, 0, 1'b0);
        put_chunk(TYPE_IEND, 0, 1'b0);
        emit_stream(1'b1);
        // lead bytes just outside and at the edges of the lowercase range
        put_sig();
        put_chunk(TYPE_IHDR, 1, 1'b0);
        put_chunk({8'h60, 24'h616263}, 1, 1'b0);
        emit_stream(1'b1);
        put_sig();
        put_chunk(TYPE_IHDR, 0, 1'b0);
        put_chunk({8'h7B, 24'h616263}, 0, 1'b0);
        emit_stream(1'b0);
        put_sig();
        put_chunk(TYPE_IHDR, 2, 1'b0);
        put_chunk({LOWER_A, 24'h414243}, 1, 1'b0);
        put_chunk({LOWER_Z, 24'h7A7A7A}, 0, 1'b0);
        put_chunk(TYPE_IDAT, 3, 1'b0);
        put_chunk(TYPE_IEND, 0, 1'b1);
        emit_stream(1'b1);
        // idat before ihdr, then iend without idat
        put_sig();
        put_chunk(TYPE_IDAT, 4, 1'b0);
        emit_stream(1'b1);
        put_sig();
        put_chunk(TYPE_IHDR, 1, 1'b0);
        put_chunk(TYPE_IEND, 0, 1'b0);
        emit_stream(1'b1);
        // full 32-bit chunk length, cut short
        put_sig();
        put_chunk(TYPE_IHDR, 1, 1'b0);
        put_word(32'hFFFF_FFFF);
        put_word(TYPE_IDAT);
        repeat (5) sbuf.push_back(8'($urandom));
        emit_stream(1'b1);

        // random streams, each pausing for the pipe to empty before it starts
        for (int s = 0; s < 2; s++)
        begin
            if (s == 1)
            begin
                // long receiver hold while single-byte streams keep coming
                for (int k = 0; k < 16; k++)
                begin
                    push_req((k % 2 == 0) ? 8'h00 : 8'hFF, 1'b1,
                             1'($urandom_range(0, 1)), k == 0, 1'b0);
                end
                streams_built += 16;
            end
            build_random_stream(1'b1);
        end

        repeat (8) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (byte_queue.size() != 0 || item_valid)
            @(negedge clk);
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("%0d streams, %0d bytes taken, %0d verdicts checked", streams_built,
                 bytes_taken, checked);
        $display("valid %0d, signature %0d, order %0d, critical %0d, crc %0d, truncated %0d",
                 tally[VERDICT_OK], tally[VERDICT_BAD_SIG], tally[VERDICT_ORDER],
                 tally[VERDICT_CRITICAL], tally[VERDICT_CRC], tally[VERDICT_TRUNCATED]);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
design/png_sv_pkg.sv
design/png_stream_validator_core.sv
test/testbench.sv
